// ----- rtl/tbc_pkg.sv -----
// Shared constants, types and register codes for the threshold blob centroid block.
`default_nettype none

package tbc_pkg;

    // Frame geometry and result format
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int FRACTION_BITS = 8;

    // Fixed field widths
    localparam int PIX_W    = 8;
    localparam int IMG_W    = 13;
    localparam int AREA_W   = 25;
    localparam int CENTER_W = 20;

    // Derived counter and accumulator widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LINE_W = (COL_W + 1 > IMG_W) ? COL_W + 1 : IMG_W;
    localparam int SUM_W  = AREA_W + ((COL_W > ROW_W) ? COL_W : ROW_W);
    localparam int DIV_W  = SUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam longint unsigned AREA_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);

    // Luma weights, 14 fraction bits
    localparam int GRAY_SUM_W  = 22;
    localparam int GRAY_SHIFT  = 14;
    localparam int WEIGHT_B    = 1868;
    localparam int WEIGHT_G    = 9617;
    localparam int WEIGHT_R    = 4899;
    localparam int GRAY_ROUND  = 8192;

    // Frame queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_COLOR_INPUT = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_IMAGE_WIDTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic             color_input;
        logic [PIX_W-1:0] threshold;
        logic [IMG_W-1:0] image_width;
    } cfg_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  column_sum;
        logic [SUM_W-1:0]  row_sum;
    } frame_sum_t;

    typedef struct packed {
        logic       push;
        frame_sum_t data;
    } queue_wr_t;

    typedef struct packed {
        logic empty;
        logic almost_full;
    } queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tbc_pixel_if.sv -----
// Pixel stream channel: one request carries one pixel and its frame-end mark.
`default_nettype none

interface tbc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [tbc_pkg::PIX_W-1:0] gray_or_blue;
    logic [tbc_pkg::PIX_W-1:0] green;
    logic [tbc_pkg::PIX_W-1:0] red;
    logic                      frame_end;

    modport source (output valid, output gray_or_blue, output green, output red,
                    output frame_end, input ready);
    modport sink   (input valid, input gray_or_blue, input green, input red,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/tbc_result_if.sv -----
// Result channel: one request carries the blob summary of one frame.
`default_nettype none

interface tbc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [tbc_pkg::AREA_W-1:0]   area;
    logic [tbc_pkg::CENTER_W-1:0] center_column;
    logic [tbc_pkg::CENTER_W-1:0] center_row;

    modport source (output valid, output found, output area, output center_column,
                    output center_row, input ready);
    modport sink   (input valid, input found, input area, input center_column,
                    input center_row, output ready);
endinterface

`default_nettype wire

// ----- rtl/tbc_front.sv -----
// Front end: gray conversion, thresholding, coordinate tracking and moment accumulation.
`default_nettype none

module tbc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tbc_pixel_if.sink                 pix,
    input  wire tbc_pkg::cfg_t        cfg,
    input  wire tbc_pkg::queue_stat_t q_stat,
    output tbc_pkg::queue_wr_t        q_wr
);

    logic                           accept;
    logic [tbc_pkg::GRAY_SUM_W-1:0] gray_sum;
    logic [tbc_pkg::PIX_W-1:0]      gray;
    logic [tbc_pkg::LINE_W-1:0]     line_w;
    logic [tbc_pkg::LINE_W-1:0]     col_inc;
    logic [tbc_pkg::ROW_W:0]        row_inc;
    logic                           col_wrap;

    logic [tbc_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tbc_pkg::ROW_W-1:0]  row_reg, row_next;

    logic                       a_valid_reg;
    logic                       a_last_reg;
    logic [tbc_pkg::PIX_W-1:0]  a_gray_reg;
    logic [tbc_pkg::COL_W-1:0]  a_col_reg;
    logic [tbc_pkg::ROW_W-1:0]  a_row_reg;

    logic                       fg;
    logic [tbc_pkg::AREA_W-1:0] total_add;
    logic [tbc_pkg::SUM_W-1:0]  col_sum_add;
    logic [tbc_pkg::SUM_W-1:0]  row_sum_add;
    logic [tbc_pkg::AREA_W-1:0] total_reg, total_next;
    logic [tbc_pkg::SUM_W-1:0]  col_sum_reg, col_sum_next;
    logic [tbc_pkg::SUM_W-1:0]  row_sum_reg, row_sum_next;

    // Hold off when the queue could not take a frame already in flight
    assign pix.ready = !q_stat.almost_full;
    assign accept    = pix.valid && pix.ready;

    // Convert BGR to luma when color_input is set; otherwise pass the gray input through
    assign gray_sum = tbc_pkg::GRAY_SUM_W'(pix.gray_or_blue)
                        * tbc_pkg::GRAY_SUM_W'(tbc_pkg::WEIGHT_B)
                    + tbc_pkg::GRAY_SUM_W'(pix.green) * tbc_pkg::GRAY_SUM_W'(tbc_pkg::WEIGHT_G)
                    + tbc_pkg::GRAY_SUM_W'(pix.red) * tbc_pkg::GRAY_SUM_W'(tbc_pkg::WEIGHT_R)
                    + tbc_pkg::GRAY_SUM_W'(tbc_pkg::GRAY_ROUND);
    assign gray = cfg.color_input ? gray_sum[tbc_pkg::GRAY_SHIFT +: tbc_pkg::PIX_W]
                                  : pix.gray_or_blue;

    // Clamp the line width and advance the raster position
    always_comb
    begin
        if (cfg.image_width == '0
            || tbc_pkg::LINE_W'(cfg.image_width) > tbc_pkg::LINE_W'(tbc_pkg::MAX_WIDTH))
        begin
            line_w = tbc_pkg::LINE_W'(tbc_pkg::MAX_WIDTH);
        end
        else
        begin
            line_w = tbc_pkg::LINE_W'(cfg.image_width);
        end
        col_inc  = tbc_pkg::LINE_W'(col_reg) + tbc_pkg::LINE_W'(1);
        row_inc  = {1'b0, row_reg} + (tbc_pkg::ROW_W + 1)'(1);
        col_wrap = (col_inc >= line_w);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                if (row_inc >= (tbc_pkg::ROW_W + 1)'(tbc_pkg::MAX_HEIGHT))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[tbc_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[tbc_pkg::COL_W-1:0];
            end
            if (pix.frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
        end
    end

    // Accumulate moments of the staged pixel; drop into the queue at frame end
    always_comb
    begin
        fg = (a_gray_reg > cfg.threshold)
             && (total_reg < tbc_pkg::AREA_W'(tbc_pkg::AREA_CAP));
        total_add   = total_reg + tbc_pkg::AREA_W'(fg);
        col_sum_add = fg ? col_sum_reg + tbc_pkg::SUM_W'(a_col_reg) : col_sum_reg;
        row_sum_add = fg ? row_sum_reg + tbc_pkg::SUM_W'(a_row_reg) : row_sum_reg;

        q_wr.push            = a_valid_reg && a_last_reg;
        q_wr.data.area       = total_add;
        q_wr.data.column_sum = col_sum_add;
        q_wr.data.row_sum    = row_sum_add;

        total_next   = total_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        if (a_valid_reg)
        begin
            if (a_last_reg)
            begin
                total_next   = '0;
                col_sum_next = '0;
                row_sum_next = '0;
            end
            else
            begin
                total_next   = total_add;
                col_sum_next = col_sum_add;
                row_sum_next = row_sum_add;
            end
        end
    end

    // Control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            total_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= accept;
            total_reg   <= total_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
        end
    end

    // Stage the gray pixel with its coordinates
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_last_reg <= pix.frame_end;
            a_gray_reg <= gray;
            a_col_reg  <= col_reg;
            a_row_reg  <= row_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tbc_queue.sv -----
// Short FIFO of per-frame moment totals between the accumulator and the divider.
`default_nettype none

module tbc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tbc_pkg::queue_wr_t   q_wr,
    input  wire logic                 pop,
    output tbc_pkg::frame_sum_t       rd_data,
    output tbc_pkg::queue_stat_t      q_stat
);

    tbc_pkg::frame_sum_t        entry_reg [tbc_pkg::QDEPTH];
    logic [tbc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tbc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tbc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       full;

    assign full               = (count_reg == tbc_pkg::QCNT_W'(tbc_pkg::QDEPTH));
    assign q_stat.empty       = (count_reg == '0);
    assign q_stat.almost_full = (count_reg >= tbc_pkg::QCNT_W'(tbc_pkg::QDEPTH - 1));
    assign rd_data            = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = q_wr.push ? wr_ptr_reg + tbc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + tbc_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + tbc_pkg::QCNT_W'(q_wr.push) - tbc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed frame totals
    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !full)
        else $error("frame queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("frame queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/tbc_back.sv -----
// Back end: bit-serial division of the moment sums by the area and the result register.
`default_nettype none

module tbc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tbc_pkg::frame_sum_t  q_data,
    input  wire logic                 q_empty,
    output logic                      pop,
    tbc_result_if.source              res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } back_state_t;

    back_state_t                  state_reg, state_next;
    logic [tbc_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [tbc_pkg::AREA_W-1:0]   area_reg;
    logic [tbc_pkg::DIV_W-1:0]    col_dvd_reg, row_dvd_reg;
    logic [tbc_pkg::AREA_W-1:0]   col_rem_reg, row_rem_reg;
    logic [tbc_pkg::CENTER_W-1:0] col_q_reg, row_q_reg;
    logic [tbc_pkg::AREA_W:0]     col_step, row_step;
    logic                         found;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [tbc_pkg::AREA_W:0] div_step(
        input logic [tbc_pkg::AREA_W-1:0] rem,
        input logic                       next_bit,
        input logic [tbc_pkg::AREA_W-1:0] divisor
    );
        logic [tbc_pkg::AREA_W:0] rem_sh;
        logic [tbc_pkg::AREA_W:0] dz;
        logic                     ge;
        rem_sh = {rem, next_bit};
        dz     = {1'b0, divisor};
        ge     = (rem_sh >= dz);
        if (ge)
        begin
            rem_sh = rem_sh - dz;
        end
        return {ge, rem_sh[tbc_pkg::AREA_W-1:0]};
    endfunction

    assign col_step = div_step(col_rem_reg, col_dvd_reg[tbc_pkg::DIV_W-1], area_reg);
    assign row_step = div_step(row_rem_reg, row_dvd_reg[tbc_pkg::DIV_W-1], area_reg);

    // Sequence load, divide and hold
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    step_next  = tbc_pkg::STEP_W'(tbc_pkg::DIV_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg - tbc_pkg::STEP_W'(1);
                if (step_reg == tbc_pkg::STEP_W'(1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Load rounded dividends, then shift one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            area_reg    <= q_data.area;
            col_dvd_reg <= (tbc_pkg::DIV_W'(q_data.column_sum) << tbc_pkg::FRACTION_BITS)
                         + tbc_pkg::DIV_W'(q_data.area >> 1);
            row_dvd_reg <= (tbc_pkg::DIV_W'(q_data.row_sum) << tbc_pkg::FRACTION_BITS)
                         + tbc_pkg::DIV_W'(q_data.area >> 1);
            col_rem_reg <= '0;
            row_rem_reg <= '0;
            col_q_reg   <= '0;
            row_q_reg   <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            col_dvd_reg <= col_dvd_reg << 1;
            row_dvd_reg <= row_dvd_reg << 1;
            col_rem_reg <= col_step[tbc_pkg::AREA_W-1:0];
            row_rem_reg <= row_step[tbc_pkg::AREA_W-1:0];
            col_q_reg   <= {col_q_reg[tbc_pkg::CENTER_W-2:0], col_step[tbc_pkg::AREA_W]};
            row_q_reg   <= {row_q_reg[tbc_pkg::CENTER_W-2:0], row_step[tbc_pkg::AREA_W]};
        end
    end

    // Present the result; an empty frame reports a zero centroid
    assign found             = (area_reg != '0);
    assign res.valid         = (state_reg == ST_HOLD);
    assign res.found         = found;
    assign res.area          = area_reg;
    assign res.center_column = found ? col_q_reg : '0;
    assign res.center_row    = found ? row_q_reg : '0;

    a_div_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg != '0))
        else $error("divider running with no steps left");

    a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> ($past(state_reg) == ST_DIV))
        else $error("result raised without a finished division");

endmodule

`default_nettype wire

// ----- rtl/threshold_blob_centroid.sv -----
// Top level: configuration registers, pixel front end, frame queue and divider back end.
//
// Usage:
//   pix  - pixel stream in raster order, one request per pixel (gray, or BGR when
//          color_input is set); frame_end marks the last pixel of a frame.
//   res  - one request per frame: found, area and the centroid column and row
//          with 8 fraction bits, rounded to nearest.
//   APB  - color_input at 0x0, threshold at 0x4, image_width at 0x8; write only
//          while no frame is in progress.
// Throughput: one pixel per cycle while pix.ready is high. A frame result passes the
//   front-end stage register and the queue, then a bit-serial division (one quotient bit
//   per cycle, column and row in parallel) before res.valid rises. The back end takes a
//   new frame from the queue only after the last result is taken; the division runs
//   while the front end accepts the following frame's pixels.
// Stall: results wait in the output register; up to four finished frames queue
//   behind it, and pix.ready drops only when that queue is nearly full.
// Reset: counters, sums and the queue clear; registers return to gray input,
//   threshold 128 and width 640.
`default_nettype none

module threshold_blob_centroid (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tbc_pixel_if.sink                         pix,
    tbc_result_if.source                      res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tbc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tbc_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    tbc_pkg::cfg_t        cfg_reg, cfg_next;
    tbc_pkg::reg_index_t  reg_index;
    tbc_pkg::queue_wr_t   q_wr;
    tbc_pkg::queue_stat_t q_stat;
    tbc_pkg::frame_sum_t  q_data;
    logic                 pop;
    logic                 wr_en;

    assign pready    = 1'b1;
    assign reg_index = tbc_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en     = psel && penable && pwrite;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                tbc_pkg::REG_COLOR_INPUT: cfg_next.color_input = pwdata[0];
                tbc_pkg::REG_THRESHOLD:   cfg_next.threshold   = pwdata[tbc_pkg::PIX_W-1:0];
                tbc_pkg::REG_IMAGE_WIDTH: cfg_next.image_width = pwdata[tbc_pkg::IMG_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_index)
            tbc_pkg::REG_COLOR_INPUT: prdata = tbc_pkg::PDATA_W'(cfg_reg.color_input);
            tbc_pkg::REG_THRESHOLD:   prdata = tbc_pkg::PDATA_W'(cfg_reg.threshold);
            tbc_pkg::REG_IMAGE_WIDTH: prdata = tbc_pkg::PDATA_W'(cfg_reg.image_width);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_input <= 1'b0;
            cfg_reg.threshold   <= tbc_pkg::PIX_W'(128);
            cfg_reg.image_width <= tbc_pkg::IMG_W'(640);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tbc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_wr   (q_wr)
    );

    tbc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .pop     (pop),
        .rd_data (q_data),
        .q_stat  (q_stat)
    );

    tbc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_stat.empty),
        .pop     (pop),
        .res     (res)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the threshold blob centroid block: random pixel frames, checked results.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 1600;
    localparam int IDLE_PERCENT   = 19;

    // Pixel value styles for frame content
    localparam int STYLE_UNIFORM = 0;
    localparam int STYLE_BIMODAL = 1;
    localparam int STYLE_SPARSE  = 2;

    typedef struct {
        logic [tbc_pkg::PIX_W-1:0] gray_or_blue;
        logic [tbc_pkg::PIX_W-1:0] green;
        logic [tbc_pkg::PIX_W-1:0] red;
        logic                      frame_end;
    } pixel_t;

    typedef struct {
        logic                         found;
        logic [tbc_pkg::AREA_W-1:0]   area;
        logic [tbc_pkg::CENTER_W-1:0] center_column;
        logic [tbc_pkg::CENTER_W-1:0] center_row;
    } blob_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [tbc_pkg::PADDR_W-1:0]   paddr;
    logic [tbc_pkg::PDATA_W-1:0]   pwdata;
    logic [tbc_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    tbc_pixel_if  pix ();
    tbc_result_if res ();

    threshold_blob_centroid dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pixels waiting to be sent and blob summaries waiting to come back
    pixel_t pixel_backlog[$];
    blob_t  expected_blobs[$];
    pixel_t staged_pixel;

    // Register copies kept by the predictor
    logic                      color_mode;
    logic [tbc_pkg::PIX_W-1:0] gray_limit;
    logic [tbc_pkg::IMG_W-1:0] line_len;

    // Frame accumulators kept by the predictor
    logic [tbc_pkg::AREA_W-1:0] blob_area;
    longint unsigned            column_total;
    longint unsigned            row_total;
    int unsigned                column_at;
    int unsigned                row_at;

    int  pixels_pushed;
    int  pixels_accepted;
    int  frames_checked;
    int  settings_used;
    int  errors;
    int  idle_cycles;
    bit  steady;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rounded fixed-point mean of a coordinate sum
    function automatic logic [tbc_pkg::CENTER_W-1:0] centroid_fixed(longint unsigned total,
                                                                    longint unsigned count);
        if (count == 0)
            return '0;
        return tbc_pkg::CENTER_W'(((total << tbc_pkg::FRACTION_BITS) + (count >> 1)) / count);
    endfunction

    // Advance the predicted frame by one pixel; return 1 when the frame closes
    function automatic bit fold_pixel(pixel_t p, output blob_t summary);
        int unsigned gray;
        int unsigned span;
        gray = p.gray_or_blue;
        if (color_mode)
            gray = (int'(p.gray_or_blue) * tbc_pkg::WEIGHT_B
                    + int'(p.green) * tbc_pkg::WEIGHT_G
                    + int'(p.red) * tbc_pkg::WEIGHT_R + tbc_pkg::GRAY_ROUND)
                   >> tbc_pkg::GRAY_SHIFT;
        span = (line_len == 0 || line_len > tbc_pkg::MAX_WIDTH) ? tbc_pkg::MAX_WIDTH
                                                                : line_len;

        if (gray > gray_limit && longint'(blob_area) < tbc_pkg::AREA_CAP)
        begin
            blob_area    = blob_area + 1'b1;
            column_total = column_total + column_at;
            row_total    = row_total + row_at;
        end

        // Step the raster position, wrap at line end and after the last row
        column_at++;
        if (column_at >= span)
        begin
            column_at = 0;
            row_at++;
            if (row_at >= tbc_pkg::MAX_HEIGHT)
                row_at = 0;
        end

        summary = '{default: '0};
        if (!p.frame_end)
            return 1'b0;
        summary.found         = (blob_area != 0);
        summary.area          = blob_area;
        summary.center_column = centroid_fixed(column_total, blob_area);
        summary.center_row    = centroid_fixed(row_total, blob_area);
        blob_area    = '0;
        column_total = 0;
        row_total    = 0;
        column_at    = 0;
        row_at       = 0;
        return 1'b1;
    endfunction

    task automatic check_field(string label, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Pixel driver: hold each request until it is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            pix.valid <= 1'b0;
        else if (!pix.valid || pix.ready)
        begin
            if (pixel_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT))
            begin
                staged_pixel      = pixel_backlog.pop_front();
                pix.valid        <= 1'b1;
                pix.gray_or_blue <= staged_pixel.gray_or_blue;
                pix.green        <= staged_pixel.green;
                pix.red          <= staged_pixel.red;
                pix.frame_end    <= staged_pixel.frame_end;
            end
            else
                pix.valid <= 1'b0;
        end
    end

    // Result receiver: stall at random, never while steady is set
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
    end

    // Monitor: predict on accepted pixels, compare accepted results
    always @(posedge clk)
    begin
        pixel_t taken;
        blob_t  summary;
        blob_t  want;
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                pixels_accepted++;
                taken.gray_or_blue = pix.gray_or_blue;
                taken.green        = pix.green;
                taken.red          = pix.red;
                taken.frame_end    = pix.frame_end;
                if (fold_pixel(taken, summary))
                    expected_blobs.push_back(summary);
            end
            if (res.valid && res.ready)
            begin
                if (expected_blobs.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with no frame pending, area %0d", $time, res.area);
                end
                else
                begin
                    want = expected_blobs.pop_front();
                    frames_checked++;
                    check_field("found", want.found, res.found);
                    check_field("area", want.area, res.area);
                    check_field("center_column", want.center_column, res.center_column);
                    check_field("center_row", want.center_row, res.center_row);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no request moved for %0d cycles", $time, idle_cycles);
            $display("tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_pixel(logic [tbc_pkg::PIX_W-1:0] b, logic [tbc_pkg::PIX_W-1:0] g,
                              logic [tbc_pkg::PIX_W-1:0] r, logic last);
        pixel_t p;
        p.gray_or_blue = b;
        p.green        = g;
        p.red          = r;
        p.frame_end    = last;
        pixel_backlog.push_back(p);
        pixels_pushed++;
    endtask

    function automatic logic [tbc_pkg::PIX_W-1:0] pick_level(int style);
        case (style)
            STYLE_BIMODAL: return tbc_pkg::PIX_W'($urandom_range(1) ? $urandom_range(255, 200)
                                                                    : $urandom_range(60, 0));
            STYLE_SPARSE:  return tbc_pkg::PIX_W'(($urandom_range(7) == 0)
                                                  ? $urandom_range(255, 129)
                                                  : $urandom_range(20, 0));
            default:       return tbc_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame(int unsigned length, int style);
        logic [tbc_pkg::PIX_W-1:0] b;
        logic [tbc_pkg::PIX_W-1:0] g;
        logic [tbc_pkg::PIX_W-1:0] r;
        for (int unsigned k = 0; k < length; k++)
        begin
            b = pick_level(style);
            g = pick_level(style);
            r = pick_level(style);
            push_pixel(b, g, r, k == length - 1);
        end
    endtask

    // Wait until every pixel is taken and every result is back
    task automatic wait_results;
        while (pixels_accepted != pixels_pushed || expected_blobs.size() != 0)
            @(posedge clk);
    endtask

    // Two-phase register write; the register takes the value on the access edge
    task automatic write_reg(tbc_pkg::reg_index_t idx, logic [tbc_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tbc_pkg::REG_COLOR_INPUT: color_mode = value[0];
            tbc_pkg::REG_THRESHOLD:   gray_limit = value[tbc_pkg::PIX_W-1:0];
            tbc_pkg::REG_IMAGE_WIDTH: line_len   = value[tbc_pkg::IMG_W-1:0];
            default: ;
        endcase
    endtask

    // Drain the block, then load a new register setting
    task automatic apply_setting(logic color, logic [tbc_pkg::PIX_W-1:0] thr,
                                 logic [tbc_pkg::IMG_W-1:0] width);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(tbc_pkg::REG_COLOR_INPUT, tbc_pkg::PDATA_W'(color));
        write_reg(tbc_pkg::REG_THRESHOLD, tbc_pkg::PDATA_W'(thr));
        write_reg(tbc_pkg::REG_IMAGE_WIDTH, tbc_pkg::PDATA_W'(width));
        settings_used++;
    endtask

    initial
    begin
        int                        random_pixels;
        int                        phase;
        int                        frame_count;
        logic                      color;
        logic [tbc_pkg::PIX_W-1:0] thr;
        logic [tbc_pkg::IMG_W-1:0] width;

        // Drive every input to a known value and hold reset
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pix.valid        = 1'b0;
        pix.gray_or_blue = '0;
        pix.green        = '0;
        pix.red          = '0;
        pix.frame_end    = 1'b0;
        res.ready        = 1'b0;
        steady           = 1'b0;
        errors           = 0;
        pixels_pushed    = 0;
        pixels_accepted  = 0;
        frames_checked   = 0;
        settings_used    = 0;
        idle_cycles      = 0;
        color_mode       = 1'b0;
        gray_limit       = 8'd128;
        line_len         = 13'd640;
        blob_area        = '0;
        column_total     = 0;
        row_total        = 0;
        column_at        = 0;
        row_at           = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: threshold edge, extremes, an empty frame and a lone pixel
        push_pixel(8'd128, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd129, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd0, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);

        // Hold the sender mid-frame until all earlier results are back
        push_pixel(8'd200, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd10, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd201, 8'd0, 8'd0, 1'b0);
        wait_results();
        push_pixel(8'd202, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd203, 8'd0, 8'd0, 1'b1);

        // Color input, lowest threshold, one-pixel lines
        apply_setting(1'b1, 8'd0, 13'd1);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd1, 1'b0);
        push_pixel(8'd0, 8'd1, 8'd0, 1'b0);
        push_pixel(8'd1, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);

        // Highest threshold: nothing is foreground; zero width acts as the maximum
        apply_setting(1'b0, 8'd255, 13'd0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b1);

        // Width beyond the maximum
        apply_setting(1'b0, 8'd0, 13'd8191);
        push_pixel(8'd1, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd1, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd1, 8'd0, 8'd0, 1'b1);

        // Exact maximum width in color mode
        apply_setting(1'b1, 8'd255, 13'd4096);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);

        // Random settings and frames
        random_pixels = 0;
        phase = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            color = 1'($urandom_range(1));
            case ($urandom_range(4))
                0: thr = 8'd0;
                1: thr = 8'd255;
                default: thr = tbc_pkg::PIX_W'($urandom_range(255));
            endcase
            case ($urandom_range(9))
                0: width = tbc_pkg::IMG_W'($urandom_range(8191));
                1: width = tbc_pkg::IMG_W'(tbc_pkg::MAX_WIDTH);
                default: width = tbc_pkg::IMG_W'($urandom_range(20, 1));
            endcase
            apply_setting(color, thr, width);
            steady = (phase == 3);

            // Bursts of one-pixel frames back up the result queue
            if (phase % 6 == 5)
            begin
                frame_count = $urandom_range(30, 12);
                for (int f = 0; f < frame_count; f++)
                    send_frame(1, STYLE_UNIFORM);
                random_pixels += frame_count;
            end
            else
            begin
                frame_count = $urandom_range(8, 1);
                for (int f = 0; f < frame_count; f++)
                begin
                    int unsigned length;
                    length = ($urandom_range(7) == 0) ? $urandom_range(200, 41)
                                                      : $urandom_range(40, 1);
                    send_frame(length, $urandom_range(STYLE_SPARSE));
                    random_pixels += length;
                end
            end
            phase++;
        end

        // Let the last results come back, then settle
        wait_results();
        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: sent %0d pixels under %0d register settings", pixels_accepted,
                 settings_used + 1);
        $display("tb: compared %0d frame results, %0d mismatches", frames_checked, errors);
        if (errors == 0 && expected_blobs.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/tbc_pkg.sv
rtl/tbc_pixel_if.sv
rtl/tbc_result_if.sv
rtl/tbc_front.sv
rtl/tbc_queue.sv
rtl/tbc_back.sv
rtl/threshold_blob_centroid.sv
tb/tb.sv
